// ===== hw/rtl/bcdid_pkg.sv =====
// ----------------------------------------------------------------------------
// bcdid_pkg
// Shared types and constants of the packed-BCD integer divider.
// ----------------------------------------------------------------------------
package bcdid_pkg;

	// Fixed field width of the beats on both channels
	localparam int unsigned DATA_W        = 64;
	// Default operand size in bytes (two digits per byte)
	localparam int unsigned NUM_BYTES_DEF = 8;
	// Bits per decimal digit
	localparam int unsigned NIB_W         = 4;
	// Most subtractions made for one quotient digit
	localparam logic [NIB_W-1:0] MAX_PASSES = 4'd9;
	// Correction added to a digit that borrowed
	localparam logic [NIB_W-1:0] BCD_TEN    = 4'd10;

	// Request beat
	typedef struct packed {
		logic [DATA_W-1:0] dividend;
		logic [DATA_W-1:0] divisor;
	} req_item_t;

	// Response beat
	typedef struct packed {
		logic [DATA_W-1:0] quotient;
		logic [DATA_W-1:0] remainder;
		logic              divide_by_zero;
	} rsp_item_t;

	// Sequencer states
	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_CHECK = 5'b00010,
		S_NORM  = 5'b00100,
		S_ALIGN = 5'b01000,
		S_DIV   = 5'b10000
	} seq_state_t;

endpackage

// ===== hw/rtl/bcdid_sub_unit.sv =====
// ----------------------------------------------------------------------------
// bcdid_sub_unit
// Shared decimal compare-and-subtract unit: a - b digit by digit with borrow,
// plus the flag that b does not exceed a (raw binary compare).
// ----------------------------------------------------------------------------
module bcdid_sub_unit #(
	parameter int unsigned W = 64
) (
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	output logic [W-1:0] diff,
	output logic         le
);
	import bcdid_pkg::*;

	localparam int unsigned DIGITS = W / NIB_W;

	logic [W:0] bin_diff;
	logic [W:0] borrow_vec;

	// One binary subtract gives both the compare and every digit borrow
	assign bin_diff   = {1'b0, a} - {1'b0, b};
	assign borrow_vec = {1'b0, a} ^ {1'b0, b} ^ bin_diff;
	assign le         = ~bin_diff[W];

	// Add ten back into each digit that borrowed out
	for (genvar i = 0; i < DIGITS; i++) begin : g_digit
		assign diff[i*NIB_W +: NIB_W] = bin_diff[i*NIB_W +: NIB_W] +
			(borrow_vec[(i+1)*NIB_W] ? BCD_TEN : '0);
	end

endmodule

// ===== hw/rtl/bcd_integer_divider_core.sv =====
// ----------------------------------------------------------------------------
// bcd_integer_divider_core
// Packed-BCD restoring long divider built around one shared compare-subtract
// unit and a small sequencer.
// ----------------------------------------------------------------------------
// Sequence: a zero divisor goes straight to the divide state and a divisor above
//   the dividend is caught in the check state; otherwise the dividend's leading
//   zero digits are counted, the divisor is aligned, and each quotient digit is
//   found by repeated subtraction. One compare-subtract pass per cycle.
// Flow: one item at a time; the next request is taken once the result sits in
//   the output register, even while that result still waits.
// Reset: arst_n clears the sequencer and the output valid; no data state.
// ----------------------------------------------------------------------------
module bcd_integer_divider_core #(
	parameter int unsigned NUM_BYTES = bcdid_pkg::NUM_BYTES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  bcdid_pkg::req_item_t  req,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output bcdid_pkg::rsp_item_t  rsp
);
	import bcdid_pkg::*;

	localparam int unsigned DIGITS = NUM_BYTES * 2;
	localparam int unsigned W      = DIGITS * NIB_W;
	localparam int unsigned DW     = $clog2(DIGITS);

	seq_state_t           state_q;
	logic [W-1:0]         rem_q;
	logic [W-1:0]         dvs_q;
	logic [W-1:0]         norm_q;
	logic [W-1:0]         quo_q;
	logic [DW-1:0]        lead_q;
	logic [DW-1:0]        digit_q;
	logic [NIB_W-1:0]     cnt_q;
	logic                 dbz_q;
	logic                 done;
	logic                 rsp_load;

	logic [W-1:0]         dvd_in;
	logic [W-1:0]         dvs_in;
	logic [W-1:0]         sub_diff;
	logic                 sub_le;
	logic [DW-1:0]        top_idx;
	logic [NIB_W-1:0]     top_digit;

	assign dvd_in = req.dividend[W-1:0];
	assign dvs_in = req.divisor[W-1:0];

	// Shared compare-subtract on partial remainder and aligned divisor
	bcdid_sub_unit #(
		.W (W)
	) u_sub (
		.a    (rem_q),
		.b    (dvs_q),
		.diff (sub_diff),
		.le   (sub_le)
	);

	// Divisor digit that must line up with the dividend's leading digit
	assign top_idx   = DW'(DIGITS - 1) - lead_q;
	assign top_digit = dvs_q[top_idx*NIB_W +: NIB_W];

	assign req_ready = (state_q == S_IDLE);
	assign rsp_load  = done && (!rsp_valid || rsp_ready);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= (dvs_in == '0) ? S_DIV : S_CHECK;
					end
				end
				S_CHECK: begin
					state_q <= sub_le ? S_NORM : S_DIV;
				end
				S_NORM: begin
					if (norm_q[W-1 -: NIB_W] != '0) begin
						state_q <= S_ALIGN;
					end
				end
				S_ALIGN: begin
					if (top_digit != '0) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Finished: either a short-cut item or the last quotient digit closed
	always_comb begin
		done = 1'b0;
		if (state_q == S_DIV) begin
			done = (dbz_q || cnt_q == MAX_PASSES || !sub_le) && digit_q == '0 ||
				dbz_q || !sub_le && cnt_q == '0 && quo_q == '0 && digit_q == '0;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					rem_q   <= dvd_in;
					dvs_q   <= dvs_in;
					norm_q  <= dvd_in;
					quo_q   <= '0;
					lead_q  <= '0;
					digit_q <= '0;
					cnt_q   <= '0;
					dbz_q   <= (dvs_in == '0);
				end
			end
			S_CHECK: begin
				// Divisor above dividend: quotient stays zero, hold remainder
				dbz_q <= 1'b0;
			end
			S_NORM: begin
				if (norm_q[W-1 -: NIB_W] == '0) begin
					norm_q <= {norm_q[W-NIB_W-1:0], {NIB_W{1'b0}}};
					lead_q <= lead_q + 1'b1;
				end
			end
			S_ALIGN: begin
				if (top_digit == '0) begin
					dvs_q   <= {dvs_q[W-NIB_W-1:0], {NIB_W{1'b0}}};
					digit_q <= digit_q + 1'b1;
				end
			end
			S_DIV: begin
				if (!dbz_q) begin
					if (cnt_q != MAX_PASSES && sub_le) begin
						// Subtract one more divisor at this position
						rem_q <= sub_diff;
						cnt_q <= cnt_q + 1'b1;
					end else if (digit_q != '0) begin
						// Close this digit and move the divisor one digit right
						quo_q   <= {quo_q[W-NIB_W-1:0], cnt_q};
						dvs_q   <= {{NIB_W{1'b0}}, dvs_q[W-1:NIB_W]};
						digit_q <= digit_q - 1'b1;
						cnt_q   <= '0;
					end else if (rsp_load) begin
						quo_q <= '0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp.divide_by_zero <= dbz_q;
			rsp.remainder      <= DATA_W'(rem_q);
			if (dbz_q) begin
				rsp.quotient <= '0;
			end else begin
				rsp.quotient <= DATA_W'({quo_q[W-NIB_W-1:0], cnt_q});
			end
		end
	end

endmodule
